FILE: src/tsd_pkg.sv
package tsd_pkg;

    localparam int ADC_W    = 12;
    localparam int BAL_W    = 12;
    localparam int LEN_W    = 16;
    localparam int OFF_W    = 13;
    localparam int ANG_W    = 14;
    localparam int U_W      = 9;
    localparam int MAG_W    = 17;
    localparam int COS_W    = 18;
    localparam int D_W      = 19;
    localparam int PROD_W   = LEN_W + D_W;
    // (length * d + 50) / 4 stays below 2^32
    localparam int Q_W      = PROD_W - 3;
    localparam int RECIP_W  = 31;
    localparam int RQ_W     = Q_W + RECIP_W;
    localparam int SHAKE_W  = 28;
    localparam int STAGES   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 88;

    localparam int TURN    = 1600;
    localparam int QUARTER = 400;
    localparam int COS_DEPTH = QUARTER + 1;

    // Angle bias: three turns keep the angle nonnegative; Z is shifted a quarter back.
    localparam logic [ANG_W-1:0] BIAS_XY = ANG_W'(3 * TURN);
    localparam logic [ANG_W-1:0] BIAS_Z  = ANG_W'(3 * TURN - QUARTER);

    // floor(q / 25) = (q * RECIP) >> RECIP_SHIFT for every q below 2^32
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(64'd1374389535);
    localparam int RECIP_SHIFT = 35;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(50);

    localparam logic [COS_W+1:0] TWO_Q16 = (COS_W+2)'(131072);
    localparam logic [SHAKE_W-1:0] SHAKE_MAX = SHAKE_W'(171796071);

    localparam logic [CFG_IDX_W-1:0] REG_BAL_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BAL_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BAL_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_LEN_X = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_LEN_Y = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_LEN_Z = CFG_IDX_W'(5);

    localparam logic [BAL_W-1:0] BAL_XY_RST = BAL_W'(2000);
    localparam logic [BAL_W-1:0] BAL_Z_RST  = BAL_W'(1950);
    localparam logic [LEN_W-1:0] LEN_RST    = LEN_W'(1000);

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned SERIES_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    typedef logic [MAG_W-1:0] t_cos_mag;
    typedef t_cos_mag t_cos_table [COS_DEPTH];

    typedef struct packed {
        logic              en;
        logic [STAGES-1:0] vld;
    } t_pipe_ctl;

    // Quarter-wave cosine in Q16, Taylor series in Q30
    function automatic t_cos_mag quarter_cos(input int unsigned u);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (64'(u) * PI_Q30) / 64'd800;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = $signed(term);
        for (int n = 0; n < 10; n++) begin
            term = (term * x2) / SERIES_DIV[n];
            if (n % 2 == 1) begin
                sum = sum + $signed(term);
            end else begin
                sum = sum - $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        v = ($unsigned(sum) + 64'd8192) >> 14;
        if (v > 64'd65536) begin
            v = 64'd65536;
        end
        return MAG_W'(v);
    endfunction

    function automatic t_cos_table build_cos_table();
        t_cos_table t;
        for (int i = 0; i < COS_DEPTH; i++) begin
            t[i] = quarter_cos(i);
        end
        return t;
    endfunction

    localparam t_cos_table COS_TABLE = build_cos_table();

endpackage

FILE: src/tsd_cos_rom.sv
module tsd_cos_rom (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tsd_pkg::U_W-1:0]     i_addr,
    output logic [tsd_pkg::MAG_W-1:0]   o_mag
);

    logic [tsd_pkg::MAG_W-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= tsd_pkg::COS_TABLE[i_addr];
        end
    end

    assign o_mag = r_mag;

endmodule

FILE: src/tsd_lane.sv
module tsd_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tsd_pkg::t_pipe_ctl              i_ctl,
    input  logic [tsd_pkg::ADC_W-1:0]       i_adc,
    input  logic [tsd_pkg::BAL_W-1:0]       i_balance,
    input  logic [tsd_pkg::LEN_W-1:0]       i_length,
    input  logic [tsd_pkg::ANG_W-1:0]       i_bias,
    input  logic signed [tsd_pkg::COS_W-1:0] i_cos_init,
    output logic [tsd_pkg::SHAKE_W-1:0]     o_shake
);

    localparam int ANG_W = tsd_pkg::ANG_W;

    // stage 0: offset
    logic signed [tsd_pkg::OFF_W-1:0] r_off;
    // stage 1: folded angle
    logic [tsd_pkg::U_W-1:0]  r_u;
    logic                     r_neg1, r_pos1, r_ngo1;
    // stage 2: cosine magnitude from rom
    logic [tsd_pkg::MAG_W-1:0] rom_mag;
    logic                     r_neg2, r_pos2, r_ngo2;
    // stage 3: cosine difference
    logic signed [tsd_pkg::COS_W-1:0] r_prev_cos;
    logic                     r_prev_pos, r_prev_ngo;
    logic [tsd_pkg::D_W-1:0]  r_d;
    // stages 4..6: scale and divide by 100
    logic [tsd_pkg::PROD_W-1:0]  r_p;
    logic [tsd_pkg::RQ_W-1:0]    r_q;
    logic [tsd_pkg::SHAKE_W-1:0] r_shake;

    logic signed [tsd_pkg::OFF_W-1:0] n_off;
    logic signed [ANG_W-1:0] off_ext;
    logic [ANG_W-1:0]        ang;
    logic [ANG_W-1:0]        rem;
    logic [tsd_pkg::U_W-1:0] n_u;
    logic                    n_neg;
    logic signed [tsd_pkg::COS_W-1:0] cn;
    logic signed [tsd_pkg::COS_W+1:0] diff;
    logic                    opposite;
    logic [tsd_pkg::D_W-1:0] n_d;

    assign n_off = $signed({1'b0, i_adc}) - $signed({1'b0, i_balance});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_off <= n_off;
        end
    end

    // angle mod one turn, then quarter-wave fold
    always_comb begin
        off_ext = ANG_W'(r_off);
        ang     = $unsigned(off_ext + $signed(i_bias));
        if (ang >= ANG_W'(5 * tsd_pkg::TURN)) begin
            rem = ang - ANG_W'(5 * tsd_pkg::TURN);
        end else if (ang >= ANG_W'(4 * tsd_pkg::TURN)) begin
            rem = ang - ANG_W'(4 * tsd_pkg::TURN);
        end else if (ang >= ANG_W'(3 * tsd_pkg::TURN)) begin
            rem = ang - ANG_W'(3 * tsd_pkg::TURN);
        end else if (ang >= ANG_W'(2 * tsd_pkg::TURN)) begin
            rem = ang - ANG_W'(2 * tsd_pkg::TURN);
        end else if (ang >= ANG_W'(tsd_pkg::TURN)) begin
            rem = ang - ANG_W'(tsd_pkg::TURN);
        end else begin
            rem = ang;
        end
        if (rem <= ANG_W'(tsd_pkg::QUARTER)) begin
            n_u   = tsd_pkg::U_W'(rem);
            n_neg = 1'b0;
        end else if (rem <= ANG_W'(2 * tsd_pkg::QUARTER)) begin
            n_u   = tsd_pkg::U_W'(ANG_W'(2 * tsd_pkg::QUARTER) - rem);
            n_neg = 1'b1;
        end else if (rem <= ANG_W'(3 * tsd_pkg::QUARTER)) begin
            n_u   = tsd_pkg::U_W'(rem - ANG_W'(2 * tsd_pkg::QUARTER));
            n_neg = 1'b1;
        end else begin
            n_u   = tsd_pkg::U_W'(ANG_W'(tsd_pkg::TURN) - rem);
            n_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_u    <= n_u;
            r_neg1 <= n_neg;
            r_pos1 <= (r_off > 0);
            r_ngo1 <= (r_off < 0);
            r_neg2 <= r_neg1;
            r_pos2 <= r_pos1;
            r_ngo2 <= r_ngo1;
        end
    end

    tsd_cos_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (i_ctl.en),
        .i_addr (r_u),
        .o_mag  (rom_mag)
    );

    always_comb begin
        cn = r_neg2 ? -$signed({1'b0, rom_mag}) : $signed({1'b0, rom_mag});
        opposite = (r_prev_pos && r_ngo2) || (r_prev_ngo && r_pos2);
        if (opposite) begin
            diff = $signed(tsd_pkg::TWO_Q16) - (tsd_pkg::COS_W+2)'(r_prev_cos)
                   - (tsd_pkg::COS_W+2)'(cn);
            if (diff < 0) begin
                diff = '0;
            end
        end else begin
            diff = (tsd_pkg::COS_W+2)'(cn) - (tsd_pkg::COS_W+2)'(r_prev_cos);
            if (diff < 0) begin
                diff = -diff;
            end
        end
        n_d = tsd_pkg::D_W'($unsigned(diff));
    end

    // previous-scan cosine and offset sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cos <= i_cos_init;
            r_prev_pos <= 1'b0;
            r_prev_ngo <= 1'b0;
        end else if (i_ctl.en && i_ctl.vld[2]) begin
            r_prev_cos <= cn;
            r_prev_pos <= r_pos2;
            r_prev_ngo <= r_ngo2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_d     <= n_d;
            r_p     <= tsd_pkg::PROD_W'(i_length * r_d) + tsd_pkg::ROUND_HALF;
            r_q     <= r_p[2 +: tsd_pkg::Q_W] * tsd_pkg::RECIP;
            r_shake <= r_q[tsd_pkg::RECIP_SHIFT +: tsd_pkg::SHAKE_W];
        end
    end

    assign o_shake = r_shake;

endmodule

FILE: src/tilt_shake_displacement_top.sv
// Three-axis tilt shake displacement. One scan request (adc_x/y/z) is taken per
// clock while the output is not stalled and yields a shake_x/y/z result. Each
// axis has its own lane: offset, angle fold, cosine ROM read (401-entry quarter
// wave), cosine difference against the previous scan, then length multiply and
// divide by 100 through a reciprocal multiply. The ROM read and both multiplies
// are registered. A stalled output freezes the whole pipeline; the input is held
// off only while the output register is full and not taken.
module tilt_shake_displacement_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // adc_x[11:0], adc_y[23:12], adc_z[35:24], zero pad
    input  logic [tsd_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // shake_x[27:0], shake_y[55:28], shake_z[83:56], zero pad
    output logic [tsd_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int ADC_W   = tsd_pkg::ADC_W;
    localparam int SHAKE_W = tsd_pkg::SHAKE_W;
    localparam logic signed [tsd_pkg::COS_W-1:0] COS_INIT_XY =
        $signed({1'b0, tsd_pkg::COS_TABLE[0]});
    localparam logic signed [tsd_pkg::COS_W-1:0] COS_INIT_Z =
        -$signed({1'b0, tsd_pkg::COS_TABLE[tsd_pkg::QUARTER]});

    logic [tsd_pkg::BAL_W-1:0] r_bal_x, r_bal_y, r_bal_z;
    logic [tsd_pkg::LEN_W-1:0] r_len_x, r_len_y, r_len_z;
    logic [tsd_pkg::STAGES-1:0] r_vld;
    logic                       en;
    logic                       in_fire;
    tsd_pkg::t_pipe_ctl         ctl;
    logic [SHAKE_W-1:0]         shake_x, shake_y, shake_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal_x <= tsd_pkg::BAL_XY_RST;
            r_bal_y <= tsd_pkg::BAL_XY_RST;
            r_bal_z <= tsd_pkg::BAL_Z_RST;
            r_len_x <= tsd_pkg::LEN_RST;
            r_len_y <= tsd_pkg::LEN_RST;
            r_len_z <= tsd_pkg::LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsd_pkg::REG_BAL_X: r_bal_x <= i_cfg_data[tsd_pkg::BAL_W-1:0];
                tsd_pkg::REG_BAL_Y: r_bal_y <= i_cfg_data[tsd_pkg::BAL_W-1:0];
                tsd_pkg::REG_BAL_Z: r_bal_z <= i_cfg_data[tsd_pkg::BAL_W-1:0];
                tsd_pkg::REG_LEN_X: r_len_x <= i_cfg_data;
                tsd_pkg::REG_LEN_Y: r_len_y <= i_cfg_data;
                tsd_pkg::REG_LEN_Z: r_len_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !r_vld[tsd_pkg::STAGES-1] || i_m_axis_tready;
    assign in_fire = i_s_axis_tvalid && en;
    assign ctl.en  = en;
    assign ctl.vld = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[tsd_pkg::STAGES-2:0], in_fire};
        end
    end

    tsd_lane u_lane_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_adc      (i_s_axis_tdata[0 +: ADC_W]),
        .i_balance  (r_bal_x),
        .i_length   (r_len_x),
        .i_bias     (tsd_pkg::BIAS_XY),
        .i_cos_init (COS_INIT_XY),
        .o_shake    (shake_x)
    );

    tsd_lane u_lane_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_adc      (i_s_axis_tdata[ADC_W +: ADC_W]),
        .i_balance  (r_bal_y),
        .i_length   (r_len_y),
        .i_bias     (tsd_pkg::BIAS_XY),
        .i_cos_init (COS_INIT_XY),
        .o_shake    (shake_y)
    );

    tsd_lane u_lane_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_adc      (i_s_axis_tdata[2*ADC_W +: ADC_W]),
        .i_balance  (r_bal_z),
        .i_length   (r_len_z),
        .i_bias     (tsd_pkg::BIAS_Z),
        .i_cos_init (COS_INIT_Z),
        .o_shake    (shake_z)
    );

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[tsd_pkg::STAGES-1];
    assign o_m_axis_tdata  = {(tsd_pkg::OUT_TDATA_W - 3*SHAKE_W)'(0),
                              shake_z, shake_y, shake_x};

    a_shake_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (shake_x <= tsd_pkg::SHAKE_MAX) &&
                            (shake_y <= tsd_pkg::SHAKE_MAX) &&
                            (shake_z <= tsd_pkg::SHAKE_MAX))
        else $error("shake result above range");

    a_fire_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_vld[0])
        else $error("accepted request lost at pipeline entry");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

endmodule
